// ===== hw/rtl/mfd_pkg.sv =====
package mfd_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH       = 8;
    localparam int MAX_MESSAGE_BYTES = 64;

    // One spare slot beyond the queue depth: the tail slot is always free,
    // so incoming bytes land in place and commit just records the length and moves the tail.
    localparam int SLOT_COUNT = QUEUE_DEPTH + 1;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int IDX_W      = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
    localparam int LEN_W      = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH  = SLOT_COUNT * MAX_MESSAGE_BYTES;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    typedef enum logic [1:0] {
        MODE_BYTE_IN = 2'd0,
        MODE_DEQUEUE = 2'd1,
        MODE_PEEK    = 2'd2,
        MODE_POP     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_ENQUEUED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_BYTE_OUT  = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_POPPED    = 3'd6
    } status_t;

    // Write port of the slot RAM
    typedef struct packed {
        logic       we;
        addr_t      addr;
        logic [7:0] data;
    } ram_wr_t;

    function automatic slot_t slot_inc(input slot_t s);
        slot_t r;
        r = (s == slot_t'(SLOT_COUNT - 1)) ? '0 : slot_t'(s + slot_t'(1));
        return r;
    endfunction

    function automatic slot_t slot_dec(input slot_t s);
        slot_t r;
        r = (s == '0) ? slot_t'(SLOT_COUNT - 1) : slot_t'(s - slot_t'(1));
        return r;
    endfunction

    // Byte address of a slot entry
    function automatic addr_t ram_addr(input slot_t s, input idx_t i);
        addr_t a;
        a = addr_t'(addr_t'(s) * addr_t'(MAX_MESSAGE_BYTES)) + addr_t'(i);
        return a;
    endfunction

endpackage

// ===== hw/rtl/message_fifo_dedup_core.sv =====
// Judged-message, pop and empty-queue results are registered at the accepting edge; a dequeue
//   or peek first reads the head byte from the RAM, then registers one byte a cycle while the
//   output is not held back. New items are taken only while idle and the output register is
//   free, so a dequeue or peek holds off new items until its last byte (one RAM read port).
// Reset (rst_n, async, active low): pointers, counts, flags and handshake state clear;
//   the slot RAM is not cleared and needs no clearing pass.
module message_fifo_dedup_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       empty_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic [3:0] item_count,
    output logic       irq_line
);
    import mfd_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } state_t;

    localparam len_t LEN_MAX = len_t'(MAX_MESSAGE_BYTES);

    state_t     state_reg, state_next;
    slot_t      head_reg, head_next;
    slot_t      tail_reg, tail_next;
    count_t     count_reg, count_next;
    len_t       prev_len_reg, prev_len_next;
    len_t       in_len_reg, in_len_next;
    logic       mism_reg, mism_next;
    logic       ovf_reg, ovf_next;
    slot_t      sh_reg, sh_next;
    len_t       slen_reg, slen_next;
    idx_t       sidx_reg, sidx_next;

    logic       out_valid_reg, out_valid_next;
    status_t    out_status_reg, out_status_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic [3:0] out_count_reg, out_count_next;
    logic       out_irq_reg, out_irq_next;

    len_t       slot_len [SLOT_COUNT];
    logic       len_we;
    // Length being committed this cycle
    len_t       commit_len;

    ram_wr_t    ram_wr;
    addr_t      ram_raddr;
    logic [7:0] ram_rdata;

    mode_t      mode_c;
    logic       in_fire;
    logic       out_free;

    assign mode_c   = mode_t'(mode);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    mfd_slot_ram u_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Slot length table, written on commit, read at the head
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            slot_len[tail_reg] <= commit_len;
        end
    end

    // Next-state logic
    always_comb
    begin
        logic    append;
        len_t    len_a;
        logic    mism_a;
        logic    ovf_a;
        len_t    head_len;
        status_t judged;

        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        prev_len_next   = prev_len_reg;
        in_len_next     = in_len_reg;
        mism_next       = mism_reg;
        ovf_next        = ovf_reg;
        sh_next         = sh_reg;
        slen_next       = slen_reg;
        sidx_next       = sidx_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        out_irq_next    = out_irq_reg;

        ram_wr.we       = 1'b0;
        ram_wr.addr     = ram_addr(tail_reg, in_len_reg[IDX_W-1:0]);
        ram_wr.data     = data_byte;
        len_we          = 1'b0;
        commit_len      = in_len_reg;

        append   = 1'b0;
        len_a    = in_len_reg;
        mism_a   = mism_reg;
        ovf_a    = ovf_reg;
        head_len = slot_len[head_reg];
        judged   = ST_ENQUEUED;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode_c == MODE_BYTE_IN)
                    begin
                        // Collect the byte in the free tail slot, compare against previous
                        append = !(last_byte && empty_message);
                        if (append)
                        begin
                            if (in_len_reg < LEN_MAX)
                            begin
                                ram_wr.we = 1'b1;
                                if ((in_len_reg < prev_len_reg) && (ram_rdata != data_byte))
                                begin
                                    mism_a = 1'b1;
                                end
                                len_a = len_t'(in_len_reg + len_t'(1));
                            end
                            else
                            begin
                                ovf_a = 1'b1;
                            end
                        end

                        if (last_byte)
                        begin
                            // Judge the finished message
                            commit_len = len_a;
                            if (ovf_a)
                            begin
                                judged = ST_TOO_LONG;
                            end
                            else if (count_reg >= count_t'(QUEUE_DEPTH))
                            begin
                                judged = ST_FULL;
                            end
                            else if ((len_a == prev_len_reg) && !mism_a)
                            begin
                                judged = ST_DUPLICATE;
                            end
                            else
                            begin
                                judged        = ST_ENQUEUED;
                                len_we        = 1'b1;
                                prev_len_next = len_a;
                                tail_next     = slot_inc(tail_reg);
                                count_next    = count_t'(count_reg + count_t'(1));
                            end
                            in_len_next     = '0;
                            mism_next       = 1'b0;
                            ovf_next        = 1'b0;
                            out_valid_next  = 1'b1;
                            out_status_next = judged;
                            out_byte_next   = 8'd0;
                            out_last_next   = 1'b1;
                        end
                        else
                        begin
                            in_len_next = len_a;
                            mism_next   = mism_a;
                            ovf_next    = ovf_a;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_EMPTY;
                        out_byte_next   = 8'd0;
                        out_last_next   = 1'b1;
                    end
                    else if (mode_c == MODE_POP)
                    begin
                        head_next       = slot_inc(head_reg);
                        count_next      = count_t'(count_reg - count_t'(1));
                        out_valid_next  = 1'b1;
                        out_status_next = ST_POPPED;
                        out_byte_next   = 8'd0;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        // Dequeue or peek: dequeue removes the head right away
                        if (mode_c == MODE_DEQUEUE)
                        begin
                            head_next  = slot_inc(head_reg);
                            count_next = count_t'(count_reg - count_t'(1));
                        end
                        if (head_len == '0)
                        begin
                            if (mode_c == MODE_DEQUEUE)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_POPPED;
                                out_byte_next   = 8'd0;
                                out_last_next   = 1'b1;
                            end
                        end
                        else
                        begin
                            state_next = S_STREAM;
                            sh_next    = head_reg;
                            slen_next  = head_len;
                            sidx_next  = '0;
                        end
                    end
                end
            end

            S_STREAM:
            begin
                // One head byte per free output slot
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_BYTE_OUT;
                    out_byte_next   = ram_rdata;
                    out_last_next   = (len_t'(sidx_reg) + len_t'(1)) == slen_reg;
                    if ((len_t'(sidx_reg) + len_t'(1)) == slen_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sidx_next = idx_t'(sidx_reg + idx_t'(1));
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_count_next = out_valid_next && !(out_valid_reg && !out_ready)
                         ? 4'(count_next) : out_count_reg;
        out_irq_next   = out_valid_next && !(out_valid_reg && !out_ready)
                         ? (count_next != '0) : out_irq_reg;

        // Aim the read port at what the next cycle will need
        if (state_next == S_STREAM)
        begin
            ram_raddr = ram_addr(sh_next, sidx_next);
        end
        else
        begin
            ram_raddr = ram_addr(slot_dec(tail_next), in_len_next[IDX_W-1:0]);
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            prev_len_reg   <= '0;
            in_len_reg     <= '0;
            mism_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            sh_reg         <= '0;
            slen_reg       <= '0;
            sidx_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_ENQUEUED;
            out_byte_reg   <= 8'd0;
            out_last_reg   <= 1'b0;
            out_count_reg  <= 4'd0;
            out_irq_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            prev_len_reg   <= prev_len_next;
            in_len_reg     <= in_len_next;
            mism_reg       <= mism_next;
            ovf_reg        <= ovf_next;
            sh_reg         <= sh_next;
            slen_reg       <= slen_next;
            sidx_reg       <= sidx_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            out_count_reg  <= out_count_next;
            out_irq_reg    <= out_irq_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign item_count = out_count_reg;
    assign irq_line   = out_irq_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(QUEUE_DEPTH))
        else $error("held count above queue depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_stream_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STREAM) |-> ((len_t'(sidx_reg) < slen_reg) && (slen_reg != '0)))
        else $error("stream index past message length");

    a_in_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_len_reg <= LEN_MAX)
        else $error("incoming length above maximum");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(in_fire) || $past(state_reg == S_STREAM)))
        else $error("result appeared without an item or a stream");

endmodule

// ===== hw/rtl/mfd_slot_ram.sv =====
module mfd_slot_ram (
    input  logic            clk,
    input  mfd_pkg::ram_wr_t wr,
    input  mfd_pkg::addr_t  raddr,
    output logic [7:0]      rdata
);
    import mfd_pkg::*;

    logic [7:0] mem [RAM_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read, write data forwarded on an address hit
    always_ff @(posedge clk)
    begin
        if (wr.we && (wr.addr == raddr))
        begin
            rdata <= wr.data;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
